// ===== rtl/core/bisection_tree_neighbors_unit_macros.svh =====
// ----------------------------------------------------------------------------
// bisection_tree_neighbors_unit_macros
// assertion macros used by the checker file of this block
// ----------------------------------------------------------------------------
`ifndef BISECTION_TREE_NEIGHBORS_UNIT_MACROS_SVH
`define BISECTION_TREE_NEIGHBORS_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btn assertion failed");

// next-cycle implication, disabled in reset
`define BTN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btn assertion failed");

`endif

// ===== rtl/core/btn_pkg.sv =====
// ----------------------------------------------------------------------------
// btn_pkg
// shared types and constants of the bisection tree neighbors unit
// ----------------------------------------------------------------------------
package btn_pkg;

   localparam int RANK_W   = 16;
   localparam int COUNT_W  = 17;
   localparam int INDEX_W  = 4;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   // largest usable process count
   localparam logic [COUNT_W-1:0] MAX_COUNT = 17'h10000;

   // register indexes, decoded from the word address
   localparam logic REG_PROCESS_COUNT = 1'b0;
   localparam logic REG_TREE_MODE     = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_STEP = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture rank, set up the range
      logic step;       // one bisection step
      logic emit_none;  // emit the no-child result
      logic emit_root;  // emit the rank zero result of mode one
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;          // range holds one rank or fewer
      logic any_child;     // at least one child emitted
      logic root_special;  // mode one and rank zero asked
   } status_type;

endpackage

// ===== rtl/core/btn_csr.sv =====
// ----------------------------------------------------------------------------
// btn_csr
// configuration registers behind the apb-style port, with count clamping
// ----------------------------------------------------------------------------
module btn_csr
   import btn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready,
   output logic [COUNT_W-1:0]  count_eff,
   output logic                tree_mode
);

   logic [COUNT_W-1:0] process_count_ff, process_count_in;
   logic               tree_mode_ff, tree_mode_in;
   logic               wr_en;
   logic               reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // register write decode
   always_comb begin
      process_count_in = process_count_ff;
      tree_mode_in     = tree_mode_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PROCESS_COUNT: process_count_in = pwdata[COUNT_W-1:0];
            REG_TREE_MODE:     tree_mode_in     = pwdata[0];
            default:           process_count_in = process_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff <= COUNT_W'(1);
         tree_mode_ff     <= 1'b0;
      end else begin
         process_count_ff <= process_count_in;
         tree_mode_ff     <= tree_mode_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_PROCESS_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, process_count_ff};
         REG_TREE_MODE:     prdata = {{(DATA_W-1){1'b0}}, tree_mode_ff};
         default:           prdata = '0;
      endcase
   end

   // zero counts as one rank, large counts saturate
   always_comb begin
      if (process_count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (process_count_ff > MAX_COUNT) begin
         count_eff = MAX_COUNT;
      end else begin
         count_eff = process_count_ff;
      end
   end

   assign tree_mode = tree_mode_ff;

endmodule

// ===== rtl/core/btn_ctrl.sv =====
// ----------------------------------------------------------------------------
// btn_ctrl
// sequencer: accepts an item, runs bisection steps, closes the item
// ----------------------------------------------------------------------------
module btn_ctrl
   import btn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.root_special) begin
                  cmd.emit_root = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (status.done) begin
               cmd.emit_none = ~status.any_child;
               state_in      = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/btn_dp.sv =====
// ----------------------------------------------------------------------------
// btn_dp
// bisection datapath: range registers, child accounting, result register
// ----------------------------------------------------------------------------
module btn_dp
   import btn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [RANK_W-1:0]   req_rank,
   input  logic [COUNT_W-1:0]  count_eff,
   input  logic                tree_mode,
   output logic                rsp_valid,
   output logic                rsp_has_child,
   output logic [INDEX_W-1:0]  rsp_child_index,
   output logic [RANK_W-1:0]   rsp_child_rank,
   output logic [RANK_W-1:0]   rsp_child_subtree,
   output logic [RANK_W-1:0]   rsp_descendants_so_far,
   output logic [RANK_W-1:0]   rsp_parent_rank,
   output logic                rsp_last
);

   logic [RANK_W-1:0]  lo_ff, lo_in;
   logic [RANK_W-1:0]  hi_ff, hi_in;
   logic [RANK_W-1:0]  me_ff, me_in;
   logic [RANK_W-1:0]  parent_ff, parent_in;
   logic [RANK_W-1:0]  sum_ff, sum_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               any_ff, any_in;

   logic               valid_ff, valid_in;
   logic               has_ff, has_in;
   logic [INDEX_W-1:0] oidx_ff, oidx_in;
   logic [RANK_W-1:0]  crank_ff, crank_in;
   logic [RANK_W-1:0]  csub_ff, csub_in;
   logic [RANK_W-1:0]  osum_ff, osum_in;
   logic [RANK_W-1:0]  opar_ff, opar_in;
   logic               last_ff, last_in;

   logic [RANK_W-1:0]  span;
   logic [RANK_W-1:0]  mid;
   logic [RANK_W-1:0]  sub;
   logic [RANK_W-1:0]  top_rank;
   logic               is_child;
   logic               root_wide;

   // one bisection step, upper half first
   assign span     = hi_ff - lo_ff;
   assign mid      = lo_ff + (span >> 1) + {{(RANK_W-1){1'b0}}, span[0]};
   assign sub      = hi_ff - mid + RANK_W'(1);
   assign is_child = (lo_ff == me_ff);

   assign top_rank  = RANK_W'(count_eff - COUNT_W'(1));
   assign root_wide = (count_eff >= COUNT_W'(2));

   assign status.done         = (hi_ff <= lo_ff);
   assign status.any_child    = any_ff;
   assign status.root_special = tree_mode & (req_rank == '0);

   // range and child bookkeeping
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      me_in     = me_ff;
      parent_in = parent_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      any_in    = any_ff;
      if (cmd.load) begin
         lo_in     = {{(RANK_W-1){1'b0}}, tree_mode};
         hi_in     = top_rank;
         me_in     = req_rank;
         parent_in = '0;
         sum_in    = '0;
         idx_in    = '0;
         any_in    = 1'b0;
      end else if (cmd.step) begin
         if (is_child) begin
            sum_in = sum_ff + sub;
            idx_in = idx_ff + INDEX_W'(1);
            any_in = 1'b1;
         end
         if (mid == me_ff) begin
            parent_in = lo_ff;
         end
         if (mid <= me_ff) begin
            lo_in = mid;
         end else begin
            hi_in = mid - RANK_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      valid_in = 1'b0;
      has_in   = has_ff;
      oidx_in  = oidx_ff;
      crank_in = crank_ff;
      csub_in  = csub_ff;
      osum_in  = osum_ff;
      opar_in  = opar_ff;
      last_in  = last_ff;
      if (cmd.emit_root) begin
         valid_in = 1'b1;
         has_in   = root_wide;
         oidx_in  = '0;
         crank_in = root_wide ? RANK_W'(1) : '0;
         csub_in  = root_wide ? top_rank : '0;
         osum_in  = root_wide ? top_rank : '0;
         opar_in  = '0;
         last_in  = 1'b1;
      end else if (cmd.emit_none) begin
         valid_in = 1'b1;
         has_in   = 1'b0;
         oidx_in  = '0;
         crank_in = '0;
         csub_in  = '0;
         osum_in  = '0;
         opar_in  = parent_ff;
         last_in  = 1'b1;
      end else if (cmd.step && is_child) begin
         valid_in = 1'b1;
         has_in   = 1'b1;
         oidx_in  = idx_ff;
         crank_in = mid;
         csub_in  = sub;
         osum_in  = sum_ff + sub;
         opar_in  = parent_ff;
         // the range closes on this rank right after its last child
         last_in  = (mid == lo_ff + RANK_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         any_ff   <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      me_ff     <= me_in;
      parent_ff <= parent_in;
      sum_ff    <= sum_in;
      idx_ff    <= idx_in;
      has_ff    <= has_in;
      oidx_ff   <= oidx_in;
      crank_ff  <= crank_in;
      csub_ff   <= csub_in;
      osum_ff   <= osum_in;
      opar_ff   <= opar_in;
      last_ff   <= last_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_has_child          = has_ff;
   assign rsp_child_index        = oidx_ff;
   assign rsp_child_rank         = crank_ff;
   assign rsp_child_subtree      = csub_ff;
   assign rsp_descendants_so_far = osum_ff;
   assign rsp_parent_rank        = opar_ff;
   assign rsp_last               = last_ff;

endmodule

// ===== rtl/core/bisection_tree_neighbors_unit.sv =====
// busy stays high while the bisection steps of an item run, one bisection step per cycle;
// a new item is accepted only after busy has fallen again.
// results appear in the cycle after the step that finds each child, one per cycle at most.
// mode one with rank zero: one result in the cycle after start, busy never rises.
// synchronous active-high reset: idle, process_count = 1, tree_mode = 0.
// results are shown for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
// bisection_tree_neighbors_unit
// parent and children of one rank in a bisection broadcast tree
// ----------------------------------------------------------------------------
module bisection_tree_neighbors_unit
   import btn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [RANK_W-1:0]   req_rank,
   output logic                rsp_valid,
   output logic                rsp_has_child,
   output logic [INDEX_W-1:0]  rsp_child_index,
   output logic [RANK_W-1:0]   rsp_child_rank,
   output logic [RANK_W-1:0]   rsp_child_subtree,
   output logic [RANK_W-1:0]   rsp_descendants_so_far,
   output logic [RANK_W-1:0]   rsp_parent_rank,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   cmd_type            cmd;
   status_type         status;
   logic [COUNT_W-1:0] count_eff;
   logic               tree_mode;

   // configuration registers
   btn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .count_eff (count_eff),
      .tree_mode (tree_mode)
   );

   // sequencer
   btn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // bisection datapath
   btn_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_rank               (req_rank),
      .count_eff              (count_eff),
      .tree_mode              (tree_mode),
      .rsp_valid              (rsp_valid),
      .rsp_has_child          (rsp_has_child),
      .rsp_child_index        (rsp_child_index),
      .rsp_child_rank         (rsp_child_rank),
      .rsp_child_subtree      (rsp_child_subtree),
      .rsp_descendants_so_far (rsp_descendants_so_far),
      .rsp_parent_rank        (rsp_parent_rank),
      .rsp_last               (rsp_last)
   );

endmodule

// ===== rtl/core/btn_checker.sv =====
// ----------------------------------------------------------------------------
// btn_checker
// port-level checks of the bisection tree neighbors unit, bound to the top
// ----------------------------------------------------------------------------
`include "bisection_tree_neighbors_unit_macros.svh"

module btn_checker
   import btn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                rsp_valid,
   input  logic                rsp_has_child,
   input  logic [INDEX_W-1:0]  rsp_child_index,
   input  logic [RANK_W-1:0]   rsp_child_rank,
   input  logic [RANK_W-1:0]   rsp_child_subtree,
   input  logic [RANK_W-1:0]   rsp_descendants_so_far,
   input  logic                rsp_last
);

   // an accepted item either keeps the unit busy or answers at once
   `BTN_ASSERT_NEXT(a_accept_acts, clock, reset, start && !busy, busy || rsp_valid)

   // a no-child result is final and carries a zero child index and child rank
   `BTN_ASSERT_NOW(a_no_child_clean, clock, reset, rsp_valid && !rsp_has_child,
      rsp_last && rsp_child_index == '0 && rsp_child_rank == '0)

   // more children to come means the item is still in work
   `BTN_ASSERT_NOW(a_more_busy, clock, reset, rsp_valid && !rsp_last, busy)

   // running descendant count covers the current child
   `BTN_ASSERT_NOW(a_sum_covers, clock, reset, rsp_valid && rsp_has_child,
      rsp_descendants_so_far >= rsp_child_subtree)

endmodule

bind bisection_tree_neighbors_unit btn_checker u_btn_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .rsp_valid              (rsp_valid),
   .rsp_has_child          (rsp_has_child),
   .rsp_child_index        (rsp_child_index),
   .rsp_child_rank         (rsp_child_rank),
   .rsp_child_subtree      (rsp_child_subtree),
   .rsp_descendants_so_far (rsp_descendants_so_far),
   .rsp_last               (rsp_last)
);

// ===== tb/tb_bisection_tree_neighbors_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bisection_tree_neighbors_unit
// self-checking bench for the bisection tree neighbors unit: ranks are issued
// through the start/busy handshake under several process counts and both tree
// modes, every result strobe is compared field by field with a local
// bisection predictor or a pinned result, and the registers are written over the csr port
// ----------------------------------------------------------------------------
module tb_bisection_tree_neighbors_unit;
   import btn_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int CHILD_CAP     = 16;
   localparam int MAX_BISECTS   = 40;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 22;
   localparam int DIRECTED_ROWS = 25;

   // one result of the block
   typedef struct packed {
      logic               has_child;
      logic [INDEX_W-1:0] child_index;
      logic [RANK_W-1:0]  child_rank;
      logic [RANK_W-1:0]  child_subtree;
      logic [RANK_W-1:0]  descendants;
      logic [RANK_W-1:0]  parent_rank;
      logic               last;
   } neighbor_type;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic               mode;
      logic [RANK_W-1:0]  rank;
      bit                 pinned;
      neighbor_type       result;
   } directed_row_type;

   // leaf answer with the root as parent, and rank one as sole child of size one
   localparam neighbor_type LEAF_AT_ROOT = '{1'b0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
   localparam neighbor_type ONE_CHILD    = '{1'b1, 4'd0, 16'd1, 16'd1, 16'd1, 16'd0, 1'b1};
   localparam neighbor_type NONE         = '0;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [RANK_W-1:0]   req_rank;
   logic                rsp_valid;
   logic                rsp_has_child;
   logic [INDEX_W-1:0]  rsp_child_index;
   logic [RANK_W-1:0]   rsp_child_rank;
   logic [RANK_W-1:0]   rsp_child_subtree;
   logic [RANK_W-1:0]   rsp_descendants_so_far;
   logic [RANK_W-1:0]   rsp_parent_rank;
   logic                rsp_last;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // register copies, the results still owed, and run statistics
   logic [COUNT_W-1:0]  cur_process_count;
   logic                cur_tree_mode;
   neighbor_type        expected_neighbors [$];
   bit                  pinned_valid;
   neighbor_type        pinned_result;
   int                  errors;
   int                  cycles;
   int                  items_accepted;
   int                  child_results;
   int                  leaf_results;
   int                  csr_writes;

   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{17'd1,       1'b0, 16'd0,     1'b1, LEAF_AT_ROOT},
      '{17'd1,       1'b0, 16'hFFFF,  1'b1, LEAF_AT_ROOT},
      '{17'd2,       1'b0, 16'd0,     1'b1, ONE_CHILD},
      '{17'd2,       1'b0, 16'd1,     1'b1, LEAF_AT_ROOT},
      '{17'd0,       1'b0, 16'd0,     1'b1, LEAF_AT_ROOT},
      '{17'h1FFFF,   1'b0, 16'd0,     1'b0, NONE},
      '{17'h1FFFF,   1'b0, 16'd1,     1'b0, NONE},
      '{17'h1FFFF,   1'b0, 16'h8000,  1'b0, NONE},
      '{17'h1FFFF,   1'b0, 16'hFFFF,  1'b0, NONE},
      '{17'h10000,   1'b1, 16'd0,     1'b1,
        '{1'b1, 4'd0, 16'd1, 16'd65535, 16'd65535, 16'd0, 1'b1}},
      '{17'h10000,   1'b1, 16'd1,     1'b0, NONE},
      '{17'h10000,   1'b1, 16'hFFFF,  1'b0, NONE},
      '{17'h10000,   1'b1, 16'h5555,  1'b0, NONE},
      '{17'd1,       1'b1, 16'd0,     1'b1, LEAF_AT_ROOT},
      '{17'd1,       1'b1, 16'd1,     1'b1, LEAF_AT_ROOT},
      '{17'd2,       1'b1, 16'd0,     1'b1, ONE_CHILD},
      '{17'd2,       1'b1, 16'd1,     1'b1, LEAF_AT_ROOT},
      '{17'd7,       1'b1, 16'd0,     1'b1,
        '{1'b1, 4'd0, 16'd1, 16'd6, 16'd6, 16'd0, 1'b1}},
      '{17'd7,       1'b1, 16'd3,     1'b0, NONE},
      '{17'd100,     1'b0, 16'd50,    1'b0, NONE},
      '{17'd100,     1'b0, 16'd99,    1'b0, NONE},
      '{17'd100,     1'b0, 16'd100,   1'b1, LEAF_AT_ROOT},
      '{17'hFFFF,    1'b0, 16'hFFFE,  1'b0, NONE},
      '{17'hFFFF,    1'b0, 16'hFFFF,  1'b1, LEAF_AT_ROOT},
      '{17'h10001,   1'b0, 16'hAAAA,  1'b0, NONE}
   };

   bisection_tree_neighbors_unit i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_rank               (req_rank),
      .rsp_valid              (rsp_valid),
      .rsp_has_child          (rsp_has_child),
      .rsp_child_index        (rsp_child_index),
      .rsp_child_rank         (rsp_child_rank),
      .rsp_child_subtree      (rsp_child_subtree),
      .rsp_descendants_so_far (rsp_descendants_so_far),
      .rsp_parent_rank        (rsp_parent_rank),
      .rsp_last               (rsp_last),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   // clock
   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // process count as the block uses it: zero means one, large values saturate
   function automatic int unsigned usable_count(input logic [COUNT_W-1:0] count);
      int unsigned n;
      n = 32'(count);
      if (n == 0) n = 1;
      if (n > 32'(MAX_COUNT)) n = 32'(MAX_COUNT);
      return n;
   endfunction

   // bisect the rank range and queue one result per child, or a leaf result
   function automatic void predict_neighbors(input logic [RANK_W-1:0] rank);
      int unsigned  n;
      int unsigned  me;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  span;
      int unsigned  mid;
      int unsigned  sub;
      int unsigned  total;
      int unsigned  parent;
      int unsigned  steps;
      int           kids;
      neighbor_type found [$];
      neighbor_type r;
      n = usable_count(cur_process_count);
      me = 32'(rank);
      r = '0;
      r.last = 1'b1;
      // mode one: rank zero only feeds rank one
      if (cur_tree_mode && me == 0) begin
         if (n >= 2) begin
            r.has_child     = 1'b1;
            r.child_rank    = RANK_W'(1);
            r.child_subtree = RANK_W'(n - 1);
            r.descendants   = RANK_W'(n - 1);
         end
         expected_neighbors.push_back(r);
         return;
      end
      lo = cur_tree_mode ? 1 : 0;
      hi = n - 1;
      total = 0;
      parent = 0;
      steps = 0;
      kids = 0;
      while (hi > lo && steps < MAX_BISECTS) begin
         span = hi - lo;
         mid = lo + (span >> 1) + (span & 1);
         if (lo == me && kids < CHILD_CAP) begin
            sub = hi - mid + 1;
            total += sub;
            r = '0;
            r.has_child     = 1'b1;
            r.child_index   = INDEX_W'(kids);
            r.child_rank    = RANK_W'(mid);
            r.child_subtree = RANK_W'(sub);
            r.descendants   = RANK_W'(total);
            found.push_back(r);
            kids++;
         end
         if (mid == me) parent = lo;
         if (mid <= me) lo = mid;
         else hi = mid - 1;
         steps++;
      end
      if (kids == 0) begin
         r = '0;
         r.parent_rank = RANK_W'(parent);
         r.last = 1'b1;
         expected_neighbors.push_back(r);
         return;
      end
      foreach (found[k]) begin
         r = found[k];
         r.parent_rank = RANK_W'(parent);
         r.last = (k == kids - 1);
         expected_neighbors.push_back(r);
      end
   endfunction

   task automatic check_field(input string name, input logic [RANK_W-1:0] want,
                              input logic [RANK_W-1:0] got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // accept items into the predictor and compare every result strobe
   always @(posedge clock) begin
      neighbor_type want;
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0) begin
            items_accepted++;
            if (pinned_valid) expected_neighbors.push_back(pinned_result);
            else predict_neighbors(req_rank);
         end
         if (rsp_valid === 1'b1) begin
            if (rsp_has_child === 1'b1) child_results++;
            else leaf_results++;
            if (expected_neighbors.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected result, expected none, got child rank %0d",
                        $time, rsp_child_rank);
            end else begin
               want = expected_neighbors.pop_front();
               check_field("has_child", RANK_W'(want.has_child), RANK_W'(rsp_has_child));
               check_field("child_index", RANK_W'(want.child_index),
                           RANK_W'(rsp_child_index));
               check_field("child_rank", want.child_rank, rsp_child_rank);
               check_field("child_subtree", want.child_subtree, rsp_child_subtree);
               check_field("descendants_so_far", want.descendants, rsp_descendants_so_far);
               check_field("parent_rank", want.parent_rank, rsp_parent_rank);
               check_field("last", RANK_W'(want.last), RANK_W'(rsp_last));
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_neighbors.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // issue one item after an idle gap; start stays high for a back-to-back item
   task automatic send_rank(input logic [RANK_W-1:0] rank, input int gap,
                            input bit pinned, input neighbor_type result);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start         <= 1'b1;
      req_rank      <= rank;
      pinned_valid  = pinned;
      pinned_result = result;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // let every owed result arrive and the block settle
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (expected_neighbors.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // csr write: setup cycle, then access cycle until pready
   task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (reg_index == REG_PROCESS_COUNT) cur_process_count = value[COUNT_W-1:0];
      else cur_tree_mode = value[0];
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // new tree shape; unused upper data bits carry noise
   task automatic set_tree(input logic [COUNT_W-1:0] count, input logic mode);
      logic [DATA_W-1:0] noise;
      drain_block();
      noise = $urandom;
      write_register(REG_PROCESS_COUNT, {noise[DATA_W-1:COUNT_W], count});
      noise = $urandom;
      write_register(REG_TREE_MODE, {noise[DATA_W-1:1], mode});
   endtask

   // stimulus
   initial begin
      logic [COUNT_W-1:0] count;
      logic [RANK_W-1:0]  rank;
      int unsigned        n;
      bit                 no_idle;
      reset             = 1'b1;
      start             = 1'b0;
      req_rank          = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      cur_process_count = 17'd1;
      cur_tree_mode     = 1'b0;
      pinned_valid      = 1'b0;
      pinned_result     = '0;
      errors            = 0;
      cycles            = 0;
      items_accepted    = 0;
      child_results     = 0;
      leaf_results      = 0;
      csr_writes        = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: reset values first, then the corners of both modes
      foreach (directed_rows[i]) begin
         if (directed_rows[i].count != cur_process_count ||
             directed_rows[i].mode != cur_tree_mode) begin
            set_tree(directed_rows[i].count, directed_rows[i].mode);
         end
         send_rank(directed_rows[i].rank, $urandom_range(0, 11),
                   directed_rows[i].pinned, directed_rows[i].result);
      end

      // random phases: mostly small trees, some at or past the limits
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            5: count = 17'd0;
            6: count = MAX_COUNT;
            7: count = 17'h1FFFF;
            8: count = COUNT_W'($urandom_range(41, 65535));
            9: count = COUNT_W'($urandom);
            default: count = COUNT_W'($urandom_range(1, 40));
         endcase
         set_tree(count, 1'($urandom_range(0, 1)));
         n = usable_count(count);
         no_idle = ($urandom_range(0, 3) == 0);
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            case ($urandom_range(0, 9))
               7: rank = RANK_W'($urandom);
               8: rank = '0;
               9: rank = RANK_W'(n - 1);
               default: rank = RANK_W'($urandom_range(0, n - 1));
            endcase
            send_rank(rank, no_idle ? 0 : $urandom_range(0, 11), 1'b0, NONE);
         end
      end

      drain_block();
      $display("covered %0d ranks over %0d register writes in both tree modes",
               items_accepted, csr_writes);
      $display("results checked: %0d naming a child, %0d leaf answers",
               child_results, leaf_results);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
